/* rtl/btnrep_pkg.sv */
// Shared types, constants and the key-code decoder for the button repeat tracker.
// No dependencies; imported by every other file of the block.
`default_nettype none

package btnrep_pkg;

    localparam int MASK_W = 18;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CODE_W = 16;
    localparam int ETYP_W = 16;
    localparam int KVAL_W = 2;
    localparam int IDX_W  = 5;

    localparam logic [ETYP_W-1:0] EVENT_KEY   = 16'h0001;
    localparam logic [KVAL_W-1:0] KEY_RELEASE = 2'd0;
    localparam logic [KVAL_W-1:0] KEY_PRESS   = 2'd1;

    // action flag carried in tuser
    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_KEY   = 1'b1;

    localparam logic REG_DELAY    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    localparam logic [2:0] DELAY_ADDR    = {REG_DELAY, 2'b00};
    localparam logic [2:0] INTERVAL_ADDR = {REG_INTERVAL, 2'b00};

    localparam logic [CFG_W-1:0] DELAY_RESET    = 16'd300;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd100;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_FRAME   = 2'd1,
        OP_PRESS   = 2'd2,
        OP_RELEASE = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [TIME_W-1:0] time_ms;
    } qentry_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } btn_lookup_t;

    function automatic btn_lookup_t btn_decode(input logic [CODE_W-1:0] code);
        btn_lookup_t r;
        r.hit = 1'b1;
        r.idx = '0;
        case (code)
            16'h005A: r.idx = 5'd0;   // up
            16'h005B: r.idx = 5'd1;   // down
            16'h005C: r.idx = 5'd2;   // left
            16'h005D: r.idx = 5'd3;   // right
            16'h005E: r.idx = 5'd4;   // A
            16'h005F: r.idx = 5'd5;   // B
            16'h0060: r.idx = 5'd6;   // X
            16'h0061: r.idx = 5'd7;   // Y
            16'h0062: r.idx = 5'd8;   // start
            16'h0063: r.idx = 5'd9;   // select
            16'h0068: r.idx = 5'd10;  // menu
            16'h0064: r.idx = 5'd11;  // L1
            16'h0066: r.idx = 5'd12;  // L2
            16'h0065: r.idx = 5'd13;  // R1
            16'h0067: r.idx = 5'd14;  // R2
            16'h006C: r.idx = 5'd15;  // plus
            16'h006D: r.idx = 5'd16;  // minus
            16'h0074: r.idx = 5'd17;  // power
            default:  r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/button_event_repeat_tracker_core.sv */
// Button event repeat tracker: one result transaction per input transaction.
// An accepted input is written to the queue, then executed into the output registers.
// Throughput: 1 transaction and 1 queue entry per cycle while m_axis_tready is high.
// Reset (rst_n low, async): all masks, times and frame time cleared; delay = 300,
// interval = 100; queue and output emptied.
// Depends on btnrep_pkg, btnrep_front, btnrep_fifo, btnrep_back.
`default_nettype none

module button_event_repeat_tracker_core
    import btnrep_pkg::*;
#(
    parameter int NUM_BUTTONS = 18
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] time_ms, [47:32] event_type, [63:48] key_code, [65:64] key_value
    input  wire logic [71:0] s_axis_tdata,
    // [0] action
    input  wire logic        s_axis_tuser,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [17:0] held, [35:18] pressed_now, [53:36] long_release,
    // [71:54] short_release, [89:72] repeat
    output logic [95:0]      m_axis_tdata
);

    logic [CFG_W-1:0] delay_reg, delay_next;
    logic [CFG_W-1:0] interval_reg, interval_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        delay_next    = delay_reg;
        interval_next = interval_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_DELAY:    delay_next    = pwdata[CFG_W-1:0];
                REG_INTERVAL: interval_next = pwdata[CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DELAY:    prdata = {{(32-CFG_W){1'b0}}, delay_reg};
            REG_INTERVAL: prdata = {{(32-CFG_W){1'b0}}, interval_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            delay_reg    <= delay_next;
            interval_reg <= interval_next;
        end
    end

    qentry_t front_entry;
    qentry_t back_entry;
    logic    q_full, q_valid, q_push, q_pop;
    logic    out_valid_reg, out_valid_next;

    btnrep_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
        .action     (s_axis_tuser),
        .time_ms    (s_axis_tdata[31:0]),
        .event_type (s_axis_tdata[47:32]),
        .key_code   (s_axis_tdata[63:48]),
        .key_value  (s_axis_tdata[65:64]),
        .entry      (front_entry)
    );

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready;
    assign q_pop         = q_valid && (!out_valid_reg || m_axis_tready);

    btnrep_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_entry),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (back_entry)
    );

    logic [MASK_W-1:0] held_m, press_m, long_m, short_m, rep_m;

    btnrep_back #(.NUM_BUTTONS(NUM_BUTTONS)) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .repeat_delay_ms    (delay_reg),
        .repeat_interval_ms (interval_reg),
        .pop                (q_pop),
        .entry              (back_entry),
        .held_mask          (held_m),
        .pressed_now_mask   (press_m),
        .long_release_mask  (long_m),
        .short_release_mask (short_m),
        .repeat_mask        (rep_m)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, rep_m, short_m, long_m, press_m, held_m};

endmodule

`default_nettype wire

/* rtl/btnrep_front.sv */
// Front end: classifies an incoming transaction into a queue entry
// (frame tick, press, release or no-op). Depends on btnrep_pkg.
`default_nettype none

module btnrep_front
    import btnrep_pkg::*;
#(
    parameter int NUM_BUTTONS = 18
)
(
    input  wire logic              action,
    input  wire logic [TIME_W-1:0] time_ms,
    input  wire logic [ETYP_W-1:0] event_type,
    input  wire logic [CODE_W-1:0] key_code,
    input  wire logic [KVAL_W-1:0] key_value,
    output qentry_t                entry
);

    btn_lookup_t lk;
    logic        key_ok;

    assign lk     = btn_decode(key_code);
    assign key_ok = (event_type == EVENT_KEY) && lk.hit && (int'(lk.idx) < NUM_BUTTONS);

    always_comb
    begin
        entry.op      = OP_NONE;
        entry.idx     = lk.idx;
        entry.time_ms = time_ms;
        if (action == ACT_FRAME)
        begin
            entry.op = OP_FRAME;
        end
        else if (key_ok && key_value == KEY_PRESS)
        begin
            entry.op = OP_PRESS;
        end
        else if (key_ok && key_value == KEY_RELEASE)
        begin
            entry.op = OP_RELEASE;
        end
    end

endmodule

`default_nettype wire

/* rtl/btnrep_fifo.sv */
// Two-entry queue of classified items between the front end and the back end.
// Depends on btnrep_pkg.
`default_nettype none

module btnrep_fifo
    import btnrep_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire qentry_t push_data,
    output logic         full,
    input  wire logic    pop,
    output logic         valid,
    output qentry_t      pop_data
);

    qentry_t     mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/btnrep_back.sv */
// Back end: holds the button state and the per-button times, executes at most one
// popped queue entry per cycle and presents the masks. Depends on btnrep_pkg.
`default_nettype none

module btnrep_back
    import btnrep_pkg::*;
#(
    parameter int NUM_BUTTONS = 18
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CFG_W-1:0] repeat_delay_ms,
    input  wire logic [CFG_W-1:0] repeat_interval_ms,
    input  wire logic             pop,
    input  wire qentry_t          entry,
    output logic [MASK_W-1:0]     held_mask,
    output logic [MASK_W-1:0]     pressed_now_mask,
    output logic [MASK_W-1:0]     long_release_mask,
    output logic [MASK_W-1:0]     short_release_mask,
    output logic [MASK_W-1:0]     repeat_mask
);

    localparam int ID_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [NUM_BUTTONS-1:0] held_reg,  held_next;
    logic [NUM_BUTTONS-1:0] press_reg, press_next;
    logic [NUM_BUTTONS-1:0] long_reg,  long_next;
    logic [NUM_BUTTONS-1:0] short_reg, short_next;
    logic [NUM_BUTTONS-1:0] rep_reg,   rep_next;
    logic [TIME_W-1:0]      start_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      start_next[NUM_BUTTONS];
    logic [TIME_W-1:0]      due_reg   [NUM_BUTTONS];
    logic [TIME_W-1:0]      due_next  [NUM_BUTTONS];
    logic [TIME_W-1:0]      frame_reg, frame_next;

    logic [ID_W-1:0]        id;
    logic [TIME_W-1:0]      dur;
    logic [CFG_W:0]         long_limit;
    logic [TIME_W-1:0]      interval_ext;

    assign id           = entry.idx[ID_W-1:0];
    assign dur          = frame_reg - start_reg[id];
    assign long_limit   = {1'b0, repeat_delay_ms} + {1'b0, repeat_interval_ms};
    assign interval_ext = {{(TIME_W-CFG_W){1'b0}}, repeat_interval_ms};

    always_comb
    begin
        held_next  = held_reg;
        press_next = press_reg;
        long_next  = long_reg;
        short_next = short_reg;
        rep_next   = rep_reg;
        start_next = start_reg;
        due_next   = due_reg;
        frame_next = frame_reg;
        if (pop)
        begin
            case (entry.op)
                OP_FRAME:
                begin
                    frame_next = entry.time_ms;
                    press_next = '0;
                    long_next  = '0;
                    short_next = '0;
                    rep_next   = '0;
                    // plain unsigned compare against the new time, no wrap fix
                    for (int i = 0; i < NUM_BUTTONS; i++)
                    begin
                        if (held_reg[i] && entry.time_ms >= due_reg[i])
                        begin
                            rep_next[i] = 1'b1;
                            due_next[i] = due_reg[i] + interval_ext;
                        end
                    end
                end
                OP_PRESS:
                begin
                    if (!held_reg[id])
                    begin
                        press_next[id] = 1'b1;
                        held_next[id]  = 1'b1;
                        start_next[id] = frame_reg;
                        due_next[id]   = frame_reg
                                       + {{(TIME_W-CFG_W){1'b0}}, repeat_delay_ms};
                    end
                end
                OP_RELEASE:
                begin
                    if (held_reg[id])
                    begin
                        if (dur > {{(TIME_W-CFG_W-1){1'b0}}, long_limit})
                        begin
                            long_next[id] = 1'b1;
                        end
                        else
                        begin
                            short_next[id] = 1'b1;
                        end
                    end
                    held_next[id]  = 1'b0;
                    rep_next[id]   = 1'b0;
                    start_next[id] = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            press_reg <= '0;
            long_reg  <= '0;
            short_reg <= '0;
            rep_reg   <= '0;
            frame_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                start_reg[i] <= '0;
                due_reg[i]   <= '0;
            end
        end
        else
        begin
            held_reg  <= held_next;
            press_reg <= press_next;
            long_reg  <= long_next;
            short_reg <= short_next;
            rep_reg   <= rep_next;
            frame_reg <= frame_next;
            start_reg <= start_next;
            due_reg   <= due_next;
        end
    end

    // state only moves on a pop, so the masks double as the result register
    logic [31:0] held_ext, press_ext, long_ext, short_ext, rep_ext;

    always_comb
    begin
        held_ext  = '0;
        press_ext = '0;
        long_ext  = '0;
        short_ext = '0;
        rep_ext   = '0;
        held_ext[NUM_BUTTONS-1:0]  = held_reg;
        press_ext[NUM_BUTTONS-1:0] = press_reg;
        long_ext[NUM_BUTTONS-1:0]  = long_reg;
        short_ext[NUM_BUTTONS-1:0] = short_reg;
        rep_ext[NUM_BUTTONS-1:0]   = rep_reg;
    end

    assign held_mask          = held_ext[MASK_W-1:0];
    assign pressed_now_mask   = press_ext[MASK_W-1:0];
    assign long_release_mask  = long_ext[MASK_W-1:0];
    assign short_release_mask = short_ext[MASK_W-1:0];
    assign repeat_mask        = rep_ext[MASK_W-1:0];

endmodule

`default_nettype wire
